// File: hw/rtl/utf8r_pkg.sv
// ----------------------------------------------------------------------------
// utf8r_pkg
// Types and constants shared by the UTF-8 byte repair block.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8r_pkg;

  localparam int unsigned CountW       = 32;
  localparam int unsigned MaxRes       = 4;
  localparam int unsigned HeldDepth    = 3;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [7:0] QMARK      = 8'h3F;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] E0_SEC_MIN = 8'hA0;
  localparam logic [7:0] ED_SEC_MAX = 8'h9F;
  localparam logic [7:0] F0_SEC_MIN = 8'h90;
  localparam logic [7:0] F4_SEC_MAX = 8'h8F;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } utf8r_in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              was_replaced;
    logic              run_last;
    logic [CountW-1:0] replacement_total;
  } utf8r_out_t;

  // results caused by one item, in order
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [MaxRes-1:0]      repl;
    logic [2:0]             cnt;
  } utf8r_desc_t;

endpackage

`default_nettype wire

// File: hw/rtl/utf8r_front.sv
// ----------------------------------------------------------------------------
// utf8r_front
// Accepts items, tracks the held prefix and classifies each byte into the
// group of results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8r_front
  import utf8r_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire utf8r_in_t   in_item,
  output utf8r_desc_t      desc,
  output logic             desc_push
);

  logic [HeldDepth-1:0][7:0] held_r, held_nxt;
  logic [1:0]                hc_r, hc_nxt;
  logic [2:0]                exp_r, exp_nxt;

  logic [7:0] b;
  logic       is_ascii;
  logic [2:0] lead_len;
  logic       ok;
  logic       sec_bad;

  assign b        = in_item.data_byte;
  assign is_ascii = (b <= ASCII_MAX);

  always_comb begin
    if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      lead_len = 3'd2;
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      lead_len = 3'd3;
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  assign sec_bad = (hc_r == 2'd1) &&
                   ((held_r[0] == LEAD_E0 && b < E0_SEC_MIN) ||
                    (held_r[0] == LEAD_ED && b > ED_SEC_MAX) ||
                    (held_r[0] == LEAD_F0 && b < F0_SEC_MIN) ||
                    (held_r[0] == LEAD_F4 && b > F4_SEC_MAX));
  assign ok = (b[7:6] == CONT_TAG) && !sec_bad;

  always_comb begin
    desc     = '0;
    held_nxt = held_r;
    hc_nxt   = hc_r;
    exp_nxt  = exp_r;
    if (in_fire) begin
      if (in_item.action == ACT_FLUSH) begin
        for (int i = 0; i < HeldDepth; i++) begin
          if (2'(i) < hc_r) begin
            desc.bytes[i] = QMARK;
            desc.repl[i]  = 1'b1;
          end
        end
        desc.cnt = {1'b0, hc_r};
        hc_nxt   = 2'd0;
        exp_nxt  = 3'd0;
      end else if (hc_r == 2'd0 || !ok) begin
        // broken prefix: every held byte becomes '?', then b is a fresh lead
        hc_nxt  = 2'd0;
        exp_nxt = 3'd0;
        for (int i = 0; i < HeldDepth; i++) begin
          if (2'(i) < hc_r) begin
            desc.bytes[i] = QMARK;
            desc.repl[i]  = 1'b1;
          end
        end
        desc.cnt = {1'b0, hc_r};
        if (is_ascii || lead_len == 3'd0) begin
          for (int i = 0; i < MaxRes; i++) begin
            if (3'(i) == {1'b0, hc_r}) begin
              desc.bytes[i] = is_ascii ? b : QMARK;
              desc.repl[i]  = !is_ascii;
            end
          end
          desc.cnt = {1'b0, hc_r} + 3'd1;
        end else begin
          held_nxt[0] = b;
          hc_nxt      = 2'd1;
          exp_nxt     = lead_len;
        end
      end else if (({1'b0, hc_r} + 3'd1) >= exp_r) begin
        for (int i = 0; i < HeldDepth; i++) begin
          if (2'(i) < hc_r) begin
            desc.bytes[i] = held_r[i];
          end
        end
        for (int i = 0; i < MaxRes; i++) begin
          if (3'(i) == {1'b0, hc_r}) begin
            desc.bytes[i] = b;
          end
        end
        desc.cnt = {1'b0, hc_r} + 3'd1;
        hc_nxt   = 2'd0;
        exp_nxt  = 3'd0;
      end else begin
        for (int i = 0; i < HeldDepth; i++) begin
          if (2'(i) == hc_r) begin
            held_nxt[i] = b;
          end
        end
        hc_nxt = hc_r + 2'd1;
      end
    end
  end

  assign desc_push = in_fire && (desc.cnt != 3'd0);

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (!rst_n) begin
      hc_r  <= 2'd0;
      exp_r <= 3'd0;
    end else begin
      hc_r  <= hc_nxt;
      exp_r <= exp_nxt;
    end
  end

  a_held_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r != 2'd0) |-> (({1'b0, hc_r} < exp_r) && (exp_r >= 3'd2)))
    else $error("held prefix not shorter than its sequence");

endmodule

`default_nettype wire

// File: hw/rtl/utf8r_queue.sv
// ----------------------------------------------------------------------------
// utf8r_queue
// Short register queue of result groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8r_queue
  import utf8r_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire utf8r_desc_t push_data,
  input  wire logic        pop,
  output utf8r_desc_t      head,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  utf8r_desc_t         mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == CntW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hw/rtl/utf8r_back.sv
// ----------------------------------------------------------------------------
// utf8r_back
// Serialises each result group onto the output, one result per cycle while
// out_ready is high, and keeps the saturating replacement count.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8r_back
  import utf8r_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire utf8r_desc_t head,
  input  wire logic        empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output utf8r_out_t       out_item
);

  utf8r_desc_t       desc_r;
  logic [1:0]        idx_r, idx_nxt;
  logic              busy_r, busy_nxt;
  logic [CountW-1:0] total_r, total_nxt;
  logic              last;
  logic              fire;
  logic              repl;

  assign last  = (({1'b0, idx_r} + 3'd1) == desc_r.cnt);
  assign fire  = busy_r && out_ready;
  assign pop   = !empty && (!busy_r || (fire && last));
  assign repl  = desc_r.repl[idx_r];

  assign out_valid = busy_r;

  always_comb begin
    total_nxt = total_r;
    if (repl && total_r != '1) begin
      total_nxt = total_r + 1'b1;
    end
  end

  assign out_item.out_byte          = desc_r.bytes[idx_r];
  assign out_item.was_replaced      = repl;
  assign out_item.run_last          = last;
  assign out_item.replacement_total = total_nxt;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (fire) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc_r <= head;
    end
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= 2'd0;
      total_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      if (fire) begin
        total_r <= total_nxt;
      end
    end
  end

  a_group_size: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (desc_r.cnt != 3'd0 && desc_r.cnt <= 3'(MaxRes)))
    else $error("bad result group size");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (total_r >= $past(total_r)))
    else $error("replacement count went down");

endmodule

`default_nettype wire

// File: hw/rtl/utf8_malformed_byte_replacer.sv
// ----------------------------------------------------------------------------
// utf8_malformed_byte_replacer
// Strict UTF-8 checker that replaces bytes of malformed sequences by '?'.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_item: one byte (action 0) or an end of
// text mark (action 1) per item. Output channel out_valid/out_ready/out_item:
// one byte per item, with a replaced flag, run_last on the final result of
// an input item, and the saturating replacement count including that result.
// A well-formed multi-byte sequence comes out on the item that completes it;
// a broken one gives a '?' per held byte, then the new byte is taken as a lead.
// An input item gives zero to four results.
// Path: with the output free, an accepted item's results are written into the
// queue, then loaded into the serialiser's group register, which drives them.
// Throughput: one input item per cycle while each gives at most one result
// and the output is free; an item with more results holds the output while
// they go out, and the two-entry queue between classifier and serialiser
// absorbs such bursts. in_ready falls only when that queue is full; an output
// stall backs up into the queue first. Reset (rst_n low, synchronous) empties
// the queue and clears the held prefix and the replacement count.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_malformed_byte_replacer
  import utf8r_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire utf8r_in_t  in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output utf8r_out_t      out_item
);

  utf8r_desc_t desc;
  utf8r_desc_t head;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  logic        in_fire;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  utf8r_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .desc      (desc),
    .desc_push (push)
  );

  utf8r_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (desc),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  utf8r_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: tb/utf8_malformed_byte_replacer_tb.sv
// ----------------------------------------------------------------------------
// utf8_malformed_byte_replacer_tb
// Self-checking bench for the strict UTF-8 byte repair block.
// ----------------------------------------------------------------------------
// Drives text bytes and end-of-text marks through the input channel and keeps
// its own model of the held prefix and the replacement count. Every result is
// matched against the oldest predicted one. Directed items cover the range
// limits of the second byte, invalid leads, broken sequences and end of text.
// Random text follows, mostly well-formed characters with some noise, plus a
// stream with no idling and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_malformed_byte_replacer_tb;
  import utf8r_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandItems   = 180;
  localparam int unsigned SteadyItems = 60;
  localparam int unsigned HoldItems   = 40;
  localparam int unsigned HoldCycles  = 160;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxPrints   = 20;
  localparam int unsigned IdlePct     = 33;
  localparam logic [7:0]  CONT_MIN    = 8'h80;
  localparam logic [7:0]  CONT_MAX    = 8'hBF;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  utf8r_in_t  in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  utf8r_out_t out_item;

  // model of the block
  logic [7:0]        seq_bytes [HeldDepth];
  logic [1:0]        seq_len    = '0;
  logic [2:0]        seq_need   = '0;
  logic [CountW-1:0] repl_total = '0;
  utf8r_out_t        step_out [MaxRes];
  int                step_n;
  utf8r_out_t        expected_q [$];

  int   err_cnt   = 0;
  int   n_sent    = 0;
  int   n_results = 0;
  int   n_stalls  = 0;
  int   cycles    = 0;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  logic hold_go   = 1'b0;
  int   hold_left = 0;

  utf8_malformed_byte_replacer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  function automatic void emit_byte(input logic [7:0] b, input logic repl);
    utf8r_out_t r;
    if (step_n >= MaxRes) return;
    if (repl && repl_total != '1) repl_total++;
    r.out_byte          = b;
    r.was_replaced      = repl;
    r.run_last          = 1'b0;
    r.replacement_total = repl_total;
    step_out[step_n]    = r;
    step_n++;
  endfunction

  function automatic void start_lead(input logic [7:0] b);
    if (b <= ASCII_MAX) begin
      emit_byte(b, 1'b0);
      return;
    end
    if (b >= LEAD2_MIN && b <= LEAD2_MAX) seq_need = 3'd2;
    else if (b >= LEAD3_MIN && b <= LEAD3_MAX) seq_need = 3'd3;
    else if (b >= LEAD4_MIN && b <= LEAD4_MAX) seq_need = 3'd4;
    else begin
      emit_byte(QMARK, 1'b1);
      return;
    end
    seq_bytes[0] = b;
    seq_len      = 2'd1;
  endfunction

  // lead becomes '?', the rest of the prefix and the new byte are tried as leads
  function automatic void break_seq(input logic [7:0] b);
    logic [7:0] tail [2];
    int nt;
    int i;
    nt = 0;
    for (i = 1; i < seq_len; i++) begin
      tail[nt] = seq_bytes[i];
      nt++;
    end
    seq_len  = '0;
    seq_need = '0;
    emit_byte(QMARK, 1'b1);
    for (i = 0; i < nt; i++) start_lead(tail[i]);
    start_lead(b);
  endfunction

  function automatic void take_data(input logic [7:0] b);
    logic ok;
    int i;
    if (seq_len == 0) begin
      start_lead(b);
      return;
    end
    ok = (b[7:6] == CONT_TAG);
    if (ok && seq_len == 1) begin
      if (seq_bytes[0] == LEAD_E0 && b < E0_SEC_MIN) ok = 1'b0;
      if (seq_bytes[0] == LEAD_ED && b > ED_SEC_MAX) ok = 1'b0;
      if (seq_bytes[0] == LEAD_F0 && b < F0_SEC_MIN) ok = 1'b0;
      if (seq_bytes[0] == LEAD_F4 && b > F4_SEC_MAX) ok = 1'b0;
    end
    if (!ok) begin
      break_seq(b);
      return;
    end
    if (seq_len + 1 >= seq_need) begin
      for (i = 0; i < seq_len; i++) emit_byte(seq_bytes[i], 1'b0);
      emit_byte(b, 1'b0);
      seq_len  = '0;
      seq_need = '0;
      return;
    end
    seq_bytes[seq_len] = b;
    seq_len++;
  endfunction

  function automatic void predict_item(input utf8r_in_t it);
    utf8r_out_t r;
    int i;
    step_n = 0;
    if (it.action == ACT_FLUSH) begin
      for (i = 0; i < seq_len; i++) emit_byte(QMARK, 1'b1);
      seq_len  = '0;
      seq_need = '0;
    end else begin
      take_data(it.data_byte);
    end
    for (i = 0; i < step_n; i++) begin
      r          = step_out[i];
      r.run_last = (i == step_n - 1);
      expected_q = {expected_q, r};
    end
  endfunction

  // printing is capped, counting is not
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MaxPrints)
      $display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h", $realtime, what, got,
               want);
  endtask

  task automatic check_result(input utf8r_out_t got);
    utf8r_out_t want;
    n_results++;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(got.out_byte), 32'h0);
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
    if (got.was_replaced !== want.was_replaced)
      report_mismatch("was_replaced", 32'(got.was_replaced), 32'(want.was_replaced));
    if (got.run_last !== want.run_last)
      report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
    if (got.replacement_total !== want.replacement_total)
      report_mismatch("replacement_total", got.replacement_total, want.replacement_total);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_item(in_item);
      if (out_valid && out_ready) check_result(out_item);
      if (in_valid && !in_ready) n_stalls++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = HoldCycles;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IdlePct);
    end
  end

  function automatic utf8r_in_t data_item(input logic [7:0] b);
    utf8r_in_t it;
    it.action    = ACT_DATA;
    it.data_byte = b;
    return it;
  endfunction

  function automatic utf8r_in_t flush_item();
    utf8r_in_t it;
    it.action    = ACT_FLUSH;
    it.data_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(CONT_MIN, CONT_MAX));
  endfunction

  function automatic logic [7:0] legal_second(input logic [7:0] lead);
    if (lead == LEAD_E0) return 8'($urandom_range(E0_SEC_MIN, CONT_MAX));
    if (lead == LEAD_ED) return 8'($urandom_range(CONT_MIN, ED_SEC_MAX));
    if (lead == LEAD_F0) return 8'($urandom_range(F0_SEC_MIN, CONT_MAX));
    if (lead == LEAD_F4) return 8'($urandom_range(CONT_MIN, F4_SEC_MAX));
    return cont_byte();
  endfunction

  function automatic logic [7:0] bad_second(input logic [7:0] lead);
    if (lead == LEAD_E0) return 8'($urandom_range(CONT_MIN, E0_SEC_MIN - 1));
    if (lead == LEAD_ED) return 8'($urandom_range(ED_SEC_MAX + 1, CONT_MAX));
    if (lead == LEAD_F0) return 8'($urandom_range(CONT_MIN, F0_SEC_MIN - 1));
    if (lead == LEAD_F4) return 8'($urandom_range(F4_SEC_MAX + 1, CONT_MAX));
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, ASCII_MAX));
    return 8'($urandom_range(CONT_MAX + 1, 255));
  endfunction

  task automatic send_item(input utf8r_in_t it);
    int gap;
    gap = 0;
    if (!tx_steady)
      while ($urandom_range(0, 99) < IdlePct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic send_char(input int len);
    logic [7:0] lead;
    int i;
    case (len)
      1: lead = 8'($urandom_range(0, ASCII_MAX));
      2: lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
      3: lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
      default: lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
    endcase
    send_item(data_item(lead));
    if (len > 1) send_item(data_item(legal_second(lead)));
    for (i = 2; i < len; i++) send_item(data_item(cont_byte()));
  endtask

  task automatic send_noise();
    logic [7:0] lead;
    logic [7:0] specials [4];
    int i;
    specials = '{LEAD_E0, LEAD_ED, LEAD_F0, LEAD_F4};
    case ($urandom_range(0, 4))
      0: send_item(data_item(8'($urandom_range(0, 255))));
      1: begin
        // prefix cut short by a non-continuation byte or end of text
        lead = 8'($urandom_range(LEAD2_MIN, LEAD4_MAX));
        send_item(data_item(lead));
        if (lead >= LEAD3_MIN && $urandom_range(0, 1)) begin
          send_item(data_item(legal_second(lead)));
          if (lead >= LEAD4_MIN && $urandom_range(0, 1)) send_item(data_item(cont_byte()));
        end
        if ($urandom_range(0, 1)) send_item(flush_item());
        else send_item(data_item(bad_second(8'h00)));
      end
      2: begin
        lead = specials[$urandom_range(0, 3)];
        send_item(data_item(lead));
        send_item(data_item(bad_second(lead)));
      end
      3: send_item(flush_item());
      default: begin
        for (i = $urandom_range(1, 3); i > 0; i--) send_item(data_item(cont_byte()));
      end
    endcase
  endtask

  task automatic test_legal_extremes();
    send_item(data_item(8'h00));
    send_item(data_item(ASCII_MAX));
    send_item(data_item(LEAD2_MAX));
    send_item(data_item(CONT_MAX));
    send_item(data_item(LEAD_ED));
    send_item(data_item(ED_SEC_MAX));
    send_item(data_item(CONT_MAX));
    send_item(data_item(LEAD_F0));
    send_item(data_item(F0_SEC_MIN));
    send_item(data_item(CONT_MIN));
    send_item(data_item(CONT_MIN));
  endtask

  task automatic test_broken_sequences();
    send_item(data_item(LEAD2_MIN - 8'd1));
    send_item(data_item(8'hFF));
    send_item(data_item(LEAD_E0));
    send_item(data_item(E0_SEC_MIN - 8'd1));
    send_item(data_item(LEAD_F4));
    send_item(data_item(F4_SEC_MAX + 8'd1));
    // three held bytes then ASCII: four results from one item
    send_item(data_item(LEAD4_MIN + 8'd1));
    send_item(data_item(CONT_MIN));
    send_item(data_item(CONT_MIN));
    send_item(data_item(8'h41));
  endtask

  task automatic test_end_of_text();
    send_item(data_item(LEAD3_MIN + 8'd1));
    send_item(data_item(CONT_MIN));
    send_item(flush_item());
    send_item(flush_item());
  endtask

  task automatic test_random_text();
    int stop_at;
    stop_at = n_sent + RandItems;
    while (n_sent < stop_at) begin
      if ($urandom_range(0, 99) < 75) send_char($urandom_range(1, 4));
      else send_noise();
      if ($urandom_range(0, 99) < 3) wait_drained();
    end
  endtask

  task automatic test_steady_stream();
    int stop_at;
    stop_at   = n_sent + SteadyItems;
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    while (n_sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) send_char($urandom_range(1, 4));
      else send_noise();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_output_holdoff();
    int stop_at;
    stop_at   = n_sent + HoldItems;
    hold_go   = 1'b1;
    tx_steady = 1'b1;
    while (n_sent < stop_at) begin
      if ($urandom_range(0, 1)) send_noise();
      else send_char($urandom_range(1, 4));
    end
    tx_steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    test_legal_extremes();
    test_broken_sequences();
    test_end_of_text();
    test_random_text();
    test_steady_stream();
    test_output_holdoff();
    $display("Sent %0d items, checked %0d output bytes with %0d replacements.", n_sent,
             n_results, repl_total);
    $display("Input held back for %0d cycles; %0d mismatches.", n_stalls, err_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/utf8r_pkg.sv
hw/rtl/utf8r_front.sv
hw/rtl/utf8r_queue.sv
hw/rtl/utf8r_back.sv
hw/rtl/utf8_malformed_byte_replacer.sv
tb/utf8_malformed_byte_replacer_tb.sv
